// File: hdl/assert_macros.svh
// assertion macros used by the elevator order controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define EOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition now implies a condition in the next cycle
`define EOC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/eoc_pkg.sv
// types and constants of the elevator order controller
`default_nettype none

package eoc_pkg;

    localparam int FLOORS  = 4;
    localparam int FLOOR_W = $clog2(FLOORS);
    localparam int TICK_W  = 16;

    localparam logic [FLOORS-1:0] TOP_BIT    = FLOORS'(1) << (FLOORS - 1);
    localparam logic [FLOORS-1:0] BOTTOM_BIT = FLOORS'(1);
    localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(FLOORS - 1);

    localparam logic [TICK_W-1:0] DOOR_TICKS_RESET = TICK_W'(3);

    typedef logic signed [1:0] dir_t;
    localparam dir_t DIR_IDLE = 2'sb00;
    localparam dir_t DIR_UP   = 2'sb01;
    localparam dir_t DIR_DOWN = 2'sb11;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_EXECUTE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MOTOR_NONE = 2'd0,
        MOTOR_UP   = 2'd1,
        MOTOR_DOWN = 2'd2,
        MOTOR_STOP = 2'd3
    } motor_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } eoc_state_t;

endpackage

`default_nettype wire

// File: hdl/eoc_channels.sv
// command and response channel interfaces of the elevator order controller
`default_nettype none

interface eoc_cmd_if;
    import eoc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic               at_floor;
    logic [FLOOR_W-1:0] floor_position;
    logic               obstruction;
    logic [FLOORS-1:0]  cab_buttons;
    logic [FLOORS-1:0]  up_buttons;
    logic [FLOORS-1:0]  down_buttons;

    modport source (
        output valid, operation, at_floor, floor_position, obstruction,
               cab_buttons, up_buttons, down_buttons,
        input  ready
    );
    modport sink (
        input  valid, operation, at_floor, floor_position, obstruction,
               cab_buttons, up_buttons, down_buttons,
        output ready
    );
endinterface

interface eoc_rsp_if;
    import eoc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         motor_command;
    logic               stopped_here;
    logic               door_open;
    logic               door_lamp;
    logic [FLOOR_W-1:0] floor_indicator;
    logic signed [1:0]  travel_direction;
    logic [FLOORS-1:0]  cab_orders;
    logic [FLOORS-1:0]  up_orders;
    logic [FLOORS-1:0]  down_orders;

    modport source (
        output valid, motor_command, stopped_here, door_open, door_lamp,
               floor_indicator, travel_direction, cab_orders, up_orders, down_orders,
        input  ready
    );
    modport sink (
        input  valid, motor_command, stopped_here, door_open, door_lamp,
               floor_indicator, travel_direction, cab_orders, up_orders, down_orders,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/elevator_order_controller.sv
// elevator order controller: order latching, floor scan sequencer and door timer
// execute at a valid floor runs from accept through a scan of every floor, one at a time
//   through the shared floor comparator, to a finish step that waits for a free output
//   register; every other operation goes from accept straight to finish; one transaction at a time
// a finished response is held in the output register while the next command is taken
// reset (async, active low): orders cleared, direction idle, door counter all ones,
//   door lamp off, indicator at floor zero, door open ticks back to 3
`default_nettype none

module elevator_order_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    eoc_cmd_if.sink                    cmd,
    eoc_rsp_if.source                  rsp,
    input  wire logic                  cfg_write,
    input  wire logic [eoc_pkg::TICK_W-1:0] cfg_data
);
    import eoc_pkg::*;

    `include "assert_macros.svh"

    // sequencer
    eoc_state_t state_reg, state_next;

    // latched command
    op_t                op_reg;
    logic               exec_valid_reg;
    logic [FLOOR_W-1:0] loc_reg;
    logic               obst_reg;
    logic [FLOORS-1:0]  cab_btn_reg, up_btn_reg, down_btn_reg;

    // floor scan accumulators
    logic [FLOOR_W-1:0] idx_reg, idx_next;
    logic [FLOORS-1:0]  m_reg, m_next;
    logic               above_reg, above_next;
    logic               below_reg, below_next;
    logic               m_le_reg, m_le_next;

    // controller state; orders, direction, lamp and indicator are also shown on the response
    logic [FLOORS-1:0]  cab_reg, cab_next;
    logic [FLOORS-1:0]  up_reg, up_next;
    logic [FLOORS-1:0]  down_reg, down_next;
    dir_t               dir_reg, dir_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic               lamp_reg, lamp_next;
    logic [FLOOR_W-1:0] ind_reg, ind_next;
    logic [TICK_W-1:0]  ticks_reg;

    // response register
    logic               out_valid_reg, out_valid_next;
    motor_t             motor_reg, motor_next;
    logic               stopped_reg, stopped_next;
    logic               door_reg, door_next;

    logic               accept;
    logic               finish;

    // shared floor comparator: scan index against the current floor
    logic               cmp_gt, cmp_lt;
    logic [FLOORS-1:0]  all_orders;

    assign accept     = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == ST_IDLE);
    assign finish     = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);
    assign cmp_gt     = idx_reg > loc_reg;
    assign cmp_lt     = idx_reg < loc_reg;
    assign all_orders = cab_reg | up_reg | down_reg;

    // motor command for a direction from a floor
    function automatic motor_t drive(dir_t dir, logic [FLOOR_W-1:0] loc);
        motor_t m;
        if (dir == DIR_IDLE)
            m = MOTOR_STOP;
        else if (dir == DIR_UP && loc != TOP_FLOOR)
            m = MOTOR_UP;
        else if (dir == DIR_DOWN && loc != '0)
            m = MOTOR_DOWN;
        else
            m = MOTOR_NONE;
        return m;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cab_reg       <= '0;
            up_reg        <= '0;
            down_reg      <= '0;
            dir_reg       <= DIR_IDLE;
            elapsed_reg   <= '1;
            lamp_reg      <= 1'b0;
            ind_reg       <= '0;
            ticks_reg     <= DOOR_TICKS_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cab_reg       <= cab_next;
            up_reg        <= up_next;
            down_reg      <= down_next;
            dir_reg       <= dir_next;
            elapsed_reg   <= elapsed_next;
            lamp_reg      <= lamp_next;
            ind_reg       <= ind_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            if (cfg_write)
                ticks_reg <= cfg_data;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= op_t'(cmd.operation);
            exec_valid_reg <= cmd.at_floor && (int'(cmd.floor_position) < FLOORS);
            loc_reg        <= cmd.floor_position;
            obst_reg       <= cmd.obstruction;
            cab_btn_reg    <= cmd.cab_buttons;
            up_btn_reg     <= cmd.up_buttons;
            down_btn_reg   <= cmd.down_buttons;
        end
        m_reg       <= m_next;
        above_reg   <= above_next;
        below_reg   <= below_next;
        m_le_reg    <= m_le_next;
        motor_reg   <= motor_next;
        stopped_reg <= stopped_next;
        door_reg    <= door_next;
    end

    always_comb
    begin
        logic   stop;
        dir_t   d;
        motor_t mot;

        state_next     = state_reg;
        idx_next       = idx_reg;
        m_next         = m_reg;
        above_next     = above_reg;
        below_next     = below_reg;
        m_le_next      = m_le_reg;
        cab_next       = cab_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        dir_next       = dir_reg;
        elapsed_next   = elapsed_reg;
        lamp_next      = lamp_reg;
        ind_next       = ind_reg;
        motor_next     = motor_reg;
        stopped_next   = stopped_reg;
        door_next      = door_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        stop           = 1'b0;
        d              = dir_reg;
        mot            = MOTOR_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    above_next = 1'b0;
                    below_next = 1'b0;
                    m_le_next  = 1'b0;
                    // first nonempty mask, cab then up then down
                    if (cab_reg != '0)
                        m_next = cab_reg;
                    else if (up_reg != '0)
                        m_next = up_reg;
                    else
                        m_next = down_reg;
                    if (op_t'(cmd.operation) == OP_EXECUTE && cmd.at_floor &&
                        int'(cmd.floor_position) < FLOORS)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                // one floor per cycle: orders ahead, behind, and the first order at or below
                above_next = above_reg || (all_orders[idx_reg] && cmp_gt);
                below_next = below_reg || (all_orders[idx_reg] && cmp_lt);
                m_le_next  = m_le_reg  || (m_reg[idx_reg] && !cmp_gt);
                if (idx_reg == TOP_FLOOR)
                    state_next = ST_FINISH;
                else
                    idx_next = idx_reg + FLOOR_W'(1);
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    motor_next     = MOTOR_NONE;
                    stopped_next   = 1'b0;
                    door_next      = 1'b0;
                    unique case (op_reg)
                        OP_SAMPLE:
                        begin
                            cab_next  = cab_reg | cab_btn_reg;
                            up_next   = up_reg | (up_btn_reg & ~TOP_BIT);
                            down_next = down_reg | (down_btn_reg & ~BOTTOM_BIT);
                        end
                        OP_EXECUTE:
                        begin
                            if (exec_valid_reg)
                            begin
                                stop = cab_reg[loc_reg] ||
                                       (up_reg[loc_reg] && dir_reg != DIR_DOWN) ||
                                       (down_reg[loc_reg] && dir_reg != DIR_UP);
                                if (stop)
                                begin
                                    // stop: open the door and clear the served orders
                                    ind_next              = loc_reg;
                                    elapsed_next          = '0;
                                    cab_next[loc_reg]     = 1'b0;
                                    if (dir_reg != DIR_DOWN)
                                        up_next[loc_reg]  = 1'b0;
                                    if (dir_reg != DIR_UP)
                                        down_next[loc_reg] = 1'b0;
                                    if ((dir_reg == DIR_UP && !above_reg) ||
                                        (dir_reg == DIR_DOWN && !below_reg))
                                        dir_next = DIR_IDLE;
                                    stopped_next = 1'b1;
                                    motor_next   = MOTOR_STOP;
                                end
                                else if (dir_reg == DIR_IDLE)
                                begin
                                    // start a run toward the first pending order
                                    if (m_reg != '0)
                                    begin
                                        d          = m_le_reg ? DIR_DOWN : DIR_UP;
                                        dir_next   = d;
                                        motor_next = drive(d, loc_reg);
                                    end
                                end
                                else
                                begin
                                    // moving on: idle when nothing is ahead or at the end floor
                                    if ((dir_reg == DIR_UP && !above_reg) ||
                                        (dir_reg == DIR_DOWN && !below_reg))
                                        d = DIR_IDLE;
                                    if (loc_reg == '0 && d == DIR_DOWN)
                                        d = DIR_IDLE;
                                    if (loc_reg == TOP_FLOOR && d == DIR_UP)
                                        d = DIR_IDLE;
                                    mot        = drive(d, loc_reg);
                                    dir_next   = d;
                                    motor_next = mot;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (elapsed_reg < ticks_reg)
                            begin
                                lamp_next = 1'b1;
                                door_next = 1'b1;
                            end
                            else if (obst_reg)
                                door_next = 1'b1;
                            else
                                lamp_next = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (elapsed_reg != '1)
                                elapsed_next = elapsed_reg + TICK_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state only moves at finish, which also loads the response, so the state
    // registers show the state after the step while the response waits
    assign rsp.valid            = out_valid_reg;
    assign rsp.motor_command    = motor_reg;
    assign rsp.stopped_here     = stopped_reg;
    assign rsp.door_open        = door_reg;
    assign rsp.door_lamp        = lamp_reg;
    assign rsp.floor_indicator  = ind_reg;
    assign rsp.travel_direction = dir_reg;
    assign rsp.cab_orders       = cab_reg;
    assign rsp.up_orders        = up_reg;
    assign rsp.down_orders      = down_reg;

    // a stop always reports a stop command to the motor
    `EOC_ASSERT(a_stop_motor, !(rsp.valid && rsp.stopped_here) || (rsp.motor_command == MOTOR_STOP), "stop without motor stop")
    // the cab order at the floor just served is cleared
    `EOC_ASSERT(a_stop_clears, !(rsp.valid && rsp.stopped_here) || !rsp.cab_orders[rsp.floor_indicator], "served cab order still pending")
    // direction never takes the unused code
    `EOC_ASSERT(a_dir_code, dir_reg != 2'sb10, "bad direction code")
    // the scan runs on until the top floor has been visited
    `EOC_ASSERT_NEXT(a_scan_runs, state_reg == ST_SCAN && idx_reg != TOP_FLOOR, state_reg == ST_SCAN && !cmd.ready, "scan cut short")

endmodule

`default_nettype wire

// File: dv/eoc_status_check.sv
// checker for the elevator order controller: car status prediction and response comparison
module eoc_status_check (
    input  logic                       clk,
    input  logic                       rst_n,
    eoc_cmd_if                         cmd,
    eoc_rsp_if                         rsp,
    input  logic                       cfg_write,
    input  logic [eoc_pkg::TICK_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         awaited,
    output int                         checked,
    output int                         stops
);
    timeunit 1ns;
    timeprecision 1ps;

    import eoc_pkg::*;

    typedef struct packed {
        motor_t             motor;
        logic               stopped;
        logic               door;
        logic               lamp;
        logic [FLOOR_W-1:0] floor;
        dir_t               dir;
        logic [FLOORS-1:0]  cab;
        logic [FLOORS-1:0]  up;
        logic [FLOORS-1:0]  down;
    } car_status_t;

    // predicted car state
    logic [FLOORS-1:0]  cab_q;
    logic [FLOORS-1:0]  up_q;
    logic [FLOORS-1:0]  down_q;
    dir_t               heading;
    logic [TICK_W-1:0]  door_age;
    logic               lamp_q;
    logic [FLOOR_W-1:0] shown_floor;
    logic [TICK_W-1:0]  open_ticks;

    car_status_t status_due[$];

    // heading falls to idle when no order lies further on
    function automatic void settle_heading(logic [FLOOR_W-1:0] loc);
        logic [FLOORS-1:0] all;
        all = cab_q | up_q | down_q;
        if (heading == DIR_UP && (all >> (int'(loc) + 1)) == '0)
            heading = DIR_IDLE;
        else if (heading == DIR_DOWN && (all & ((FLOORS'(1) << loc) - FLOORS'(1))) == '0)
            heading = DIR_IDLE;
    endfunction

    function automatic motor_t motor_for(logic [FLOOR_W-1:0] loc);
        if (heading == DIR_IDLE)
            return MOTOR_STOP;
        if (heading == DIR_UP && loc < TOP_FLOOR)
            return MOTOR_UP;
        if (heading == DIR_DOWN && loc > '0)
            return MOTOR_DOWN;
        return MOTOR_NONE;
    endfunction

    function automatic car_status_t advance_car(logic [1:0] opcode, logic at,
                                                logic [FLOOR_W-1:0] pos,
                                                logic obs, logic [FLOORS-1:0] cab_b,
                                                logic [FLOORS-1:0] up_b, logic [FLOORS-1:0] down_b);
        car_status_t       s;
        logic [FLOORS-1:0] here;
        logic [FLOORS-1:0] first_mask;
        logic              halt;
        int                first;
        s = '0;
        s.motor = MOTOR_NONE;
        case (op_t'(opcode))
            OP_SAMPLE:
            begin
                cab_q  |= cab_b;
                up_q   |= up_b & ~TOP_BIT;
                down_q |= down_b & ~BOTTOM_BIT;
            end
            OP_EXECUTE:
            begin
                if (at && int'(pos) < FLOORS)
                begin
                    here = FLOORS'(1) << pos;
                    halt = (cab_q & here) != '0 ||
                           ((up_q & here) != '0 && heading != DIR_DOWN) ||
                           ((down_q & here) != '0 && heading != DIR_UP);
                    if (halt)
                    begin
                        shown_floor = pos;
                        door_age = '0;
                        cab_q &= ~here;
                        if (heading != DIR_DOWN)
                            up_q &= ~here;
                        if (heading != DIR_UP)
                            down_q &= ~here;
                        settle_heading(pos);
                        s.stopped = 1'b1;
                        s.motor = MOTOR_STOP;
                    end
                    else if (heading == DIR_IDLE)
                    begin
                        // first pending order: cab, then hall up, then hall down
                        first_mask = cab_q;
                        if (first_mask == '0)
                            first_mask = up_q;
                        if (first_mask == '0)
                            first_mask = down_q;
                        if (first_mask != '0)
                        begin
                            first = FLOORS;
                            for (int f = FLOORS - 1; f >= 0; f--)
                                if (first_mask[f])
                                    first = f;
                            heading = (int'(pos) < first) ? DIR_UP : DIR_DOWN;
                            s.motor = motor_for(pos);
                        end
                    end
                    else
                    begin
                        settle_heading(pos);
                        if (pos == '0 && heading == DIR_DOWN)
                            heading = DIR_IDLE;
                        if (pos == TOP_FLOOR && heading == DIR_UP)
                            heading = DIR_IDLE;
                        s.motor = motor_for(pos);
                    end
                end
            end
            OP_QUERY:
            begin
                if (door_age < open_ticks)
                begin
                    lamp_q = 1'b1;
                    s.door = 1'b1;
                end
                else if (obs)
                    s.door = 1'b1;
                else
                    lamp_q = 1'b0;
            end
            default:
            begin
                if (door_age != '1)
                    door_age++;
            end
        endcase
        s.lamp  = lamp_q;
        s.floor = shown_floor;
        s.dir   = heading;
        s.cab   = cab_q;
        s.up    = up_q;
        s.down  = down_q;
        return s;
    endfunction

    function automatic int report_field(string label, logic signed [16:0] want_v,
                                        logic signed [16:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        car_status_t want;
        int          bad;
        if (!rst_n)
        begin
            cab_q       = '0;
            up_q        = '0;
            down_q      = '0;
            heading     = DIR_IDLE;
            door_age    = '1;
            lamp_q      = 1'b0;
            shown_floor = '0;
            open_ticks  = DOOR_TICKS_RESET;
            status_due.delete();
            mismatches <= 0;
            awaited    <= 0;
            checked    <= 0;
            stops      <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t: response with nothing expected, motor_command %0d",
                             $time, rsp.motor_command);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = status_due.pop_front();
                    bad = report_field("motor_command", want.motor, rsp.motor_command)
                        + report_field("stopped_here", want.stopped, rsp.stopped_here)
                        + report_field("door_open", want.door, rsp.door_open)
                        + report_field("door_lamp", want.lamp, rsp.door_lamp)
                        + report_field("floor_indicator", want.floor, rsp.floor_indicator)
                        + report_field("travel_direction", want.dir, rsp.travel_direction)
                        + report_field("cab_orders", want.cab, rsp.cab_orders)
                        + report_field("up_orders", want.up, rsp.up_orders)
                        + report_field("down_orders", want.down, rsp.down_orders);
                    mismatches <= mismatches + bad;
                    checked    <= checked + 1;
                end
            end
            if (cfg_write)
                open_ticks = cfg_data;
            if (cmd.valid && cmd.ready)
            begin
                want = advance_car(cmd.operation, cmd.at_floor, cmd.floor_position,
                                   cmd.obstruction, cmd.cab_buttons, cmd.up_buttons,
                                   cmd.down_buttons);
                status_due.push_back(want);
                if (want.stopped)
                    stops <= stops + 1;
            end
            awaited <= status_due.size();
        end
    end

endmodule

// File: dv/tb.sv
// testbench top for the elevator order controller: stimulus, response backpressure and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eoc_pkg::*;

    // run length limits
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int PHASE_ITEMS    = 250;
    localparam int PHASES         = 6;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [TICK_W-1:0] cfg_data;

    int mismatches;
    int awaited;
    int checked;
    int stops;

    int items_sent;
    int burst_left;
    int squeeze_asks;

    eoc_cmd_if cmd_ch();
    eoc_rsp_if rsp_ch();

    elevator_order_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // checker sits beside the block and only observes the channels
    eoc_status_check status_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited),
        .checked    (checked),
        .stops      (stops)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5ns;
        clk = 1'b1;
        #5ns;
    end

    // hall and cab presses are sparse in a real building
    function automatic logic [FLOORS-1:0] sparse_presses();
        logic [FLOORS-1:0] m;
        m = '0;
        for (int f = 0; f < FLOORS; f++)
            m[f] = ($urandom_range(0, 3) == 0);
        return m;
    endfunction

    // offer one command transaction; called and returns at a falling edge
    // valid stays high into the next transaction unless the burst ran out
    task automatic send_cmd(op_t op, logic at, logic [FLOOR_W-1:0] pos, logic obs,
                            logic [FLOORS-1:0] cab_b, logic [FLOORS-1:0] up_b,
                            logic [FLOORS-1:0] down_b);
        cmd_ch.valid          <= 1'b1;
        cmd_ch.operation      <= op;
        cmd_ch.at_floor       <= at;
        cmd_ch.floor_position <= pos;
        cmd_ch.obstruction    <= obs;
        cmd_ch.cab_buttons    <= cab_b;
        cmd_ch.up_buttons     <= up_b;
        cmd_ch.down_buttons   <= down_b;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // gap between bursts, sometimes followed by a long unbroken burst
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // let every expected response come back before touching the register
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
    endtask

    task automatic write_open_ticks(logic [TICK_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // watchdog: a hung handshake ends the run here
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d responses still expected", LIMIT_CYCLES, awaited);
        $display("Simulation FAILED");
        $finish;
    end

    // response side: ready follows its own pattern, independent of the sender
    initial
    begin : response_sink
        int               span;
        int               kind;
        int               squeezes_done;
        logic [7:0]       pattern;
        squeezes_done = 0;
        rsp_ch.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze_asks != squeezes_done)
            begin
                // long hold-off while commands keep coming, so the block backs up
                squeezes_done = squeeze_asks;
                for (int c = 0; c < SQUEEZE_CYCLES; c++)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                end
            end
            kind    = $urandom_range(0, 19);
            span    = (kind == 19) ? $urandom_range(30, 100) : $urandom_range(10, 60);
            pattern = 8'($urandom) | 8'h01;
            for (int c = 0; c < span; c++)
            begin
                @(negedge clk);
                if (kind < 6)
                    rsp_ch.ready <= 1'b1;
                else if (kind == 19)
                    rsp_ch.ready <= 1'b0;
                else if (kind < 13)
                    rsp_ch.ready <= pattern[c % 8];
                else
                    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [TICK_W-1:0] hold_setting [PHASES];
        int                car_floor;
        int                car_way;
        int                target;

        // every input known from time zero
        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_data              = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.operation      = OP_SAMPLE;
        cmd_ch.at_floor       = 1'b0;
        cmd_ch.floor_position = '0;
        cmd_ch.obstruction    = 1'b0;
        cmd_ch.cab_buttons    = '0;
        cmd_ch.up_buttons     = '0;
        cmd_ch.down_buttons   = '0;
        items_sent            = 0;
        burst_left            = 8;
        squeeze_asks          = 0;
        car_floor             = 0;
        car_way               = 1;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed walk with the door hold at its reset value of 3 ticks
        // door counter saturated out of reset: tick stays put, door reads closed
        send_cmd(OP_TICK,    1'b0, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_QUERY,   1'b0, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        // obstruction holds the door open without lighting the lamp
        send_cmd(OP_QUERY,   1'b0, 2'd0, 1'b1, 4'h0, 4'h0, 4'h0);
        // idle with no orders, then an execute between floors
        send_cmd(OP_EXECUTE, 1'b1, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_EXECUTE, 1'b0, 2'd2, 1'b1, 4'hF, 4'hF, 4'hF);
        // every button: hall up at the top and hall down at the bottom are dropped
        send_cmd(OP_SAMPLE,  1'b0, 2'd0, 1'b0, 4'hF, 4'hF, 4'hF);
        // idle stop at the top floor clears all orders there
        send_cmd(OP_EXECUTE, 1'b1, 2'd3, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_QUERY,   1'b0, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_TICK,    1'b1, 2'd3, 1'b1, 4'hF, 4'hF, 4'hF);
        send_cmd(OP_TICK,    1'b0, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_TICK,    1'b0, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_QUERY,   1'b0, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        // start a run downward toward the lowest cab order
        send_cmd(OP_EXECUTE, 1'b1, 2'd3, 1'b0, 4'h0, 4'h0, 4'h0);
        // stops on the way down keep the heading while orders remain below
        send_cmd(OP_EXECUTE, 1'b1, 2'd2, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_EXECUTE, 1'b0, 2'd1, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_EXECUTE, 1'b1, 2'd1, 1'b0, 4'h0, 4'h0, 4'h0);
        // bottom stop leaves the hall up order, then serves it once idle
        send_cmd(OP_EXECUTE, 1'b1, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_EXECUTE, 1'b1, 2'd0, 1'b1, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_QUERY,   1'b0, 2'd0, 1'b1, 4'h0, 4'h0, 4'h0);
        // with hall up orders pending at floors one and two, an execute at the bottom starts an upward run
        send_cmd(OP_SAMPLE,  1'b0, 2'd0, 1'b0, 4'h0, 4'h4, 4'h0);
        send_cmd(OP_EXECUTE, 1'b1, 2'd0, 1'b0, 4'h0, 4'h0, 4'h0);
        // passing the top with nothing ahead drops to idle and stops
        send_cmd(OP_EXECUTE, 1'b1, 2'd3, 1'b0, 4'h0, 4'h0, 4'h0);
        send_cmd(OP_SAMPLE,  1'b1, 2'd1, 1'b1, 4'h1, 4'h0, 4'hA);
        send_cmd(OP_EXECUTE, 1'b1, 2'd1, 1'b0, 4'h0, 4'h0, 4'h0);

        // door hold settings: both extremes, the smallest nonzero, and a few ordinary ones
        hold_setting[0] = '0;
        hold_setting[1] = '1;
        hold_setting[2] = TICK_W'(1);
        hold_setting[3] = TICK_W'($urandom_range(2, 10));
        hold_setting[4] = TICK_W'($urandom_range(2, 10));
        hold_setting[5] = TICK_W'(6);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_open_ticks(hold_setting[ph]);
            if (ph == 1)
                squeeze_asks++;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: anything the fields allow
                    repeat ($urandom_range(1, 4))
                        send_cmd(op_t'($urandom_range(0, 3)), 1'($urandom), 2'($urandom),
                                 1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
                end
                else
                begin
                    // a plausible service round at the floor the car is passing
                    if ($urandom_range(0, 9) < 4)
                        send_cmd(OP_SAMPLE, 1'($urandom), 2'($urandom), 1'($urandom),
                                 sparse_presses(), sparse_presses(), sparse_presses());
                    send_cmd(OP_EXECUTE, 1'b1, FLOOR_W'(car_floor), 1'($urandom),
                             4'($urandom), 4'($urandom), 4'($urandom));
                    if ($urandom_range(0, 1) == 0)
                        send_cmd(OP_QUERY, 1'($urandom), 2'($urandom),
                                 ($urandom_range(0, 4) == 0), 4'($urandom), 4'($urandom),
                                 4'($urandom));
                    repeat ($urandom_range(0, 5))
                        send_cmd(OP_TICK, 1'($urandom), 2'($urandom), 1'($urandom),
                                 4'($urandom), 4'($urandom), 4'($urandom));
                    if ($urandom_range(0, 2) == 0)
                        send_cmd(OP_EXECUTE, 1'b0, 2'($urandom), 1'($urandom),
                                 4'($urandom), 4'($urandom), 4'($urandom));
                    // car keeps its way most of the time, turning at the ends
                    if (car_floor == 0)
                        car_way = 1;
                    else if (car_floor == FLOORS - 1)
                        car_way = -1;
                    else if ($urandom_range(0, 3) == 0)
                        car_way = -car_way;
                    car_floor += car_way;
                end
            end
        end

        // all stimulus accepted: wait for the last responses before the verdict
        drain();
        repeat (FLOORS + 4) @(negedge clk);

        $display("run covered %0d command transactions, %0d responses checked, %0d stops",
                 items_sent, checked, stops);
        $display("door hold of 3 (reset), 0, 65535, 1 and mid values, with one long response stall");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/eoc_pkg.sv
hdl/eoc_channels.sv
hdl/elevator_order_controller.sv
dv/eoc_status_check.sv
dv/tb.sv
